// ===== hw/rtl/lls_pkg.sv =====
// Shared types, codes and constants of the line sorter.
`default_nettype none
package lls_pkg;

	localparam logic [7:0] NEWLINE = 8'd10;

	localparam logic [1:0] FUNC_BYTE = 2'd0;
	localparam logic [1:0] FUNC_EOF  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam int OPW = 4;
	localparam logic [OPW-1:0] OP_NONE      = 4'd0;
	localparam logic [OPW-1:0] OP_BYTE      = 4'd1;
	localparam logic [OPW-1:0] OP_EOF       = 4'd2;
	localparam logic [OPW-1:0] OP_SORT_DONE = 4'd3;
	localparam logic [OPW-1:0] OP_BLK_START = 4'd4;
	localparam logic [OPW-1:0] OP_BLK_NEXT  = 4'd5;
	localparam logic [OPW-1:0] OP_PASS_END  = 4'd6;
	localparam logic [OPW-1:0] OP_TAKE_I    = 4'd7;
	localparam logic [OPW-1:0] OP_TAKE_J    = 4'd8;
	localparam logic [OPW-1:0] OP_P_INC     = 4'd9;
	localparam logic [OPW-1:0] OP_READ      = 4'd10;
	localparam logic [OPW-1:0] OP_FIN       = 4'd11;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        line_end;
		logic        data_end;
		logic        overflow;
		logic [10:0] line_total;
	} out_t;

	typedef struct packed {
		logic ovf;
		logic sorted;
		logic width_lt_n;
		logic lo_lt_n;
		logic i_lt_mid;
		logic j_lt_hi;
		logic cmp_done;
		logic cmp_after;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lexicographic_line_sorter.sv =====
// A byte request goes through the finish state to its result; a read request goes
// through the lookup states RW1, RW2 and RO before it. One request in flight: a new
// request is taken only after the last result has been taken. Sort request: bottom-up
// merge over ceil(log2(n)) passes, skipped after overflow, with a single compare unit.
// Reset: arst_n clears counters, flags and control; text, length and order memories
// are undefined until written and get no clearing pass.
`default_nettype none
module lexicographic_line_sorter
	import lls_pkg::*;
#(
	parameter int MAX_LINES  = 1024,
	parameter int LINE_BYTES = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	status_t        st;
	logic [OPW-1:0] op;

	lls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (in_data.func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.op        (op)
	);

	lls_datapath #(
		.MAX_LINES  (MAX_LINES),
		.LINE_BYTES (LINE_BYTES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.byte_in (in_data.in_byte),
		.st      (st),
		.res     (out_data)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/lls_ctrl.sv =====
// Controller state machine of the line sorter.
`default_nettype none
module lls_ctrl
	import lls_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [1:0]     func,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire status_t        st,
	output logic [OPW-1:0]      op
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RW1   = 4'd1;
	localparam logic [3:0] ST_RW2   = 4'd2;
	localparam logic [3:0] ST_RO    = 4'd3;
	localparam logic [3:0] ST_FIN   = 4'd4;
	localparam logic [3:0] ST_PASS  = 4'd5;
	localparam logic [3:0] ST_BLK   = 4'd6;
	localparam logic [3:0] ST_MCHK  = 4'd7;
	localparam logic [3:0] ST_MORD  = 4'd8;
	localparam logic [3:0] ST_CRD   = 4'd9;
	localparam logic [3:0] ST_CEV   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       acc;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = ST_FIN;
					case (func)
						FUNC_BYTE: op = OP_BYTE;
						FUNC_EOF: begin
							if (!st.sorted) begin
								if (st.ovf) begin
									op = OP_SORT_DONE;
								end else begin
									op      = OP_EOF;
									state_d = ST_PASS;
								end
							end
						end
						FUNC_READ: begin
							if (st.sorted)
								state_d = ST_RW1;
						end
						default: op = OP_NONE;
					endcase
				end
			end
			// lookups settle: order entry, then length and text
			ST_RW1: state_d = ST_RW2;
			ST_RW2: state_d = ST_RO;
			ST_RO: begin
				op      = OP_READ;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				op      = OP_FIN;
				state_d = ST_IDLE;
			end
			ST_PASS: begin
				if (st.width_lt_n) begin
					state_d = ST_BLK;
				end else begin
					op      = OP_SORT_DONE;
					state_d = ST_FIN;
				end
			end
			ST_BLK: begin
				if (st.lo_lt_n) begin
					op      = OP_BLK_START;
					state_d = ST_MCHK;
				end else begin
					op      = OP_PASS_END;
					state_d = ST_PASS;
				end
			end
			ST_MCHK: begin
				if (st.i_lt_mid || st.j_lt_hi) begin
					state_d = ST_MORD;
				end else begin
					op      = OP_BLK_NEXT;
					state_d = ST_BLK;
				end
			end
			ST_MORD: begin
				if (st.i_lt_mid && st.j_lt_hi) begin
					state_d = ST_CRD;
				end else if (st.i_lt_mid) begin
					op      = OP_TAKE_I;
					state_d = ST_MCHK;
				end else begin
					op      = OP_TAKE_J;
					state_d = ST_MCHK;
				end
			end
			ST_CRD: state_d = ST_CEV;
			ST_CEV: begin
				if (st.cmp_done) begin
					op      = st.cmp_after ? OP_TAKE_J : OP_TAKE_I;
					state_d = ST_MCHK;
				end else begin
					op      = OP_P_INC;
					state_d = ST_CRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != ST_IDLE)
		else $error("request accepted but controller stayed idle");
	a_fin_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> out_valid_q)
		else $error("result not presented after finish");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !acc)
		else $error("request taken while result pending");

endmodule
`default_nettype wire

// ===== hw/rtl/lls_datapath.sv =====
// Datapath of the line sorter: text, length and order memories, merge counters.
`default_nettype none
module lls_datapath
	import lls_pkg::*;
#(
	parameter int MAX_LINES  = 1024,
	parameter int LINE_BYTES = 128
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [OPW-1:0] op,
	input  wire logic [7:0]     byte_in,
	output status_t             st,
	output out_t                res
);

	localparam int LIW = $clog2(MAX_LINES);
	localparam int CW  = $clog2(MAX_LINES + 1);
	localparam int BW  = $clog2(LINE_BYTES);
	localparam int AW  = $clog2(MAX_LINES * LINE_BYTES);
	localparam int WW  = CW + 1;
	localparam int LW  = CW + 2;

	logic [7:0]     text_mem [MAX_LINES*LINE_BYTES];
	logic [BW-1:0]  len_mem  [MAX_LINES];
	logic [LIW-1:0] orda_mem [MAX_LINES];
	logic [LIW-1:0] ordb_mem [MAX_LINES];

	logic [CW-1:0] stored_q, rline_q, mid_q, hi_q, i_q, j_q, k_q;
	logic [BW-1:0] fill_q, roff_q, p_q;
	logic [WW-1:0] width_q;
	logic [LW-1:0] lo_q;
	logic          ovf_q, sorted_q, sel_q;
	logic [7:0]    ob_q;
	logic          le_q, de_q;
	out_t          out_q;

	logic [LIW-1:0] oa1_q, oa2_q, ob1_q, ob2_q, oi, oj, ord_addr1;
	logic [BW-1:0]  la_q, lb_q, nmin, off_a;
	logic [7:0]     ta_q, tb_q;
	logic [AW-1:0]  taddr_a, taddr_b, waddr;

	logic          byte_live, byte_ovf, byte_wr, is_nl, full, close;
	logic [BW-1:0] close_len;
	logic [LW:0]   mid_sum, hi_sum;
	logic [CW-1:0] mid_n, hi_n;
	logic          take, past;
	logic [LIW-1:0] take_val, stored_idx;

	assign stored_idx = stored_q[LIW-1:0];

	// intake decode
	assign is_nl     = (byte_in == NEWLINE);
	assign byte_live = (op == OP_BYTE) && !sorted_q && !ovf_q &&
	                   (stored_q < CW'(MAX_LINES));
	assign byte_ovf  = (op == OP_BYTE) && !sorted_q && !ovf_q &&
	                   (stored_q >= CW'(MAX_LINES));
	assign byte_wr   = byte_live && !is_nl;
	assign full      = byte_wr && ((9'(fill_q) + 9'd1) >= 9'(LINE_BYTES - 1));
	assign close     = (byte_live && is_nl) || full ||
	                   ((op == OP_EOF) && (fill_q != '0));
	assign close_len = full ? fill_q + BW'(1) : fill_q;
	assign waddr     = AW'(stored_idx) * AW'(LINE_BYTES) + AW'(fill_q);

	// merge bounds
	assign mid_sum = (LW+1)'(lo_q) + (LW+1)'(width_q);
	assign mid_n   = (mid_sum < (LW+1)'(stored_q)) ? CW'(mid_sum) : stored_q;
	assign hi_sum  = (LW+1)'(mid_n) + (LW+1)'(width_q);
	assign hi_n    = (hi_sum < (LW+1)'(stored_q)) ? CW'(hi_sum) : stored_q;

	// continuously registered lookups
	assign ord_addr1 = sorted_q ? rline_q[LIW-1:0] : i_q[LIW-1:0];
	assign oi        = sel_q ? ob1_q : oa1_q;
	assign oj        = sel_q ? ob2_q : oa2_q;
	assign off_a     = sorted_q ? roff_q : p_q;
	assign taddr_a   = AW'(oi) * AW'(LINE_BYTES) + AW'(off_a);
	assign taddr_b   = AW'(oj) * AW'(LINE_BYTES) + AW'(p_q);

	always_ff @(posedge clk) begin
		oa1_q <= orda_mem[ord_addr1];
		oa2_q <= orda_mem[j_q[LIW-1:0]];
		ob1_q <= ordb_mem[ord_addr1];
		ob2_q <= ordb_mem[j_q[LIW-1:0]];
		la_q  <= len_mem[oi];
		lb_q  <= len_mem[oj];
		ta_q  <= text_mem[taddr_a];
		tb_q  <= text_mem[taddr_b];
	end

	// line compare, one byte per evaluation
	assign nmin = (la_q < lb_q) ? la_q : lb_q;
	assign past = (p_q >= nmin);

	assign take     = (op == OP_TAKE_I) || (op == OP_TAKE_J);
	assign take_val = (op == OP_TAKE_J) ? oj : oi;

	always_ff @(posedge clk) begin
		if (byte_wr)
			text_mem[waddr] <= byte_in;
		if (close)
			len_mem[stored_idx] <= close_len;
		if (close)
			orda_mem[stored_idx] <= stored_idx;
		else if (take && sel_q)
			orda_mem[k_q[LIW-1:0]] <= take_val;
		if (take && !sel_q)
			ordb_mem[k_q[LIW-1:0]] <= take_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			sorted_q <= 1'b0;
			rline_q  <= '0;
			roff_q   <= '0;
			width_q  <= '0;
			lo_q     <= '0;
			mid_q    <= '0;
			hi_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			p_q      <= '0;
			sel_q    <= 1'b0;
			ob_q     <= '0;
			le_q     <= 1'b0;
			de_q     <= 1'b0;
		end else begin
			if (byte_ovf)
				ovf_q <= 1'b1;
			if (close) begin
				stored_q <= stored_q + CW'(1);
				fill_q   <= '0;
			end else if (byte_wr) begin
				fill_q <= fill_q + BW'(1);
			end
			case (op)
				OP_EOF: begin
					width_q <= WW'(1);
					lo_q    <= '0;
					sel_q   <= 1'b0;
				end
				OP_SORT_DONE: sorted_q <= 1'b1;
				OP_BLK_START: begin
					mid_q <= mid_n;
					hi_q  <= hi_n;
					i_q   <= CW'(lo_q);
					j_q   <= mid_n;
					k_q   <= CW'(lo_q);
					p_q   <= '0;
				end
				OP_BLK_NEXT: lo_q <= lo_q + LW'({width_q, 1'b0});
				OP_PASS_END: begin
					sel_q   <= !sel_q;
					width_q <= {width_q[WW-2:0], 1'b0};
					lo_q    <= '0;
				end
				OP_TAKE_I: begin
					i_q <= i_q + CW'(1);
					k_q <= k_q + CW'(1);
					p_q <= '0;
				end
				OP_TAKE_J: begin
					j_q <= j_q + CW'(1);
					k_q <= k_q + CW'(1);
					p_q <= '0;
				end
				OP_P_INC: p_q <= p_q + BW'(1);
				OP_READ: begin
					if (ovf_q || rline_q >= stored_q) begin
						de_q <= 1'b1;
					end else if (roff_q < la_q) begin
						ob_q   <= ta_q;
						roff_q <= roff_q + BW'(1);
					end else begin
						ob_q    <= NEWLINE;
						le_q    <= 1'b1;
						roff_q  <= '0;
						rline_q <= rline_q + CW'(1);
					end
				end
				OP_FIN: begin
					ob_q <= '0;
					le_q <= 1'b0;
					de_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_FIN) begin
			out_q.out_byte   <= ob_q;
			out_q.line_end   <= le_q;
			out_q.data_end   <= de_q;
			out_q.overflow   <= ovf_q;
			out_q.line_total <= 11'(stored_q);
		end
	end

	assign res = out_q;

	always_comb begin
		st.ovf        = ovf_q;
		st.sorted     = sorted_q;
		st.width_lt_n = width_q < WW'(stored_q);
		st.lo_lt_n    = lo_q < LW'(stored_q);
		st.i_lt_mid   = i_q < mid_q;
		st.j_lt_hi    = j_q < hi_q;
		st.cmp_done   = past || (ta_q != tb_q);
		st.cmp_after  = past ? (la_q > lb_q) : (ta_q > tb_q);
	end

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(MAX_LINES))
		else $error("stored line count beyond capacity");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(fill_q) < 9'(LINE_BYTES - 1))
		else $error("open line longer than allowed");
	a_sorted_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_q |=> sorted_q)
		else $error("sorted flag dropped");
	a_take_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (k_q < stored_q) && !sorted_q)
		else $error("merge write outside stored lines");

endmodule
`default_nettype wire
